/* hdl/bsp_pkg.sv */
// Package with phase and result-kind types and header layout constants for the bitmap parser.
`default_nettype none
package bsp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_GAP,
        PH_PIXELS,
        PH_PAD
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER,
        KIND_PIXEL,
        KIND_ERROR
    } t_kind;

    // Positions of the last byte of each little-endian header field.
    localparam logic [31:0] POS_OFFSET_END = 32'd13;
    localparam logic [31:0] POS_WIDTH_END  = 32'd21;
    localparam logic [31:0] POS_HEIGHT_END = 32'd25;
    localparam logic [31:0] POS_DEPTH_END  = 32'd29;
    // Row size is worked out over the two bytes after the depth field.
    localparam logic [31:0] POS_PRODUCT    = 32'd30;
    localparam logic [31:0] POS_PADDING    = 32'd31;
    localparam logic [31:0] POS_HEADER_END = 32'd53;
    localparam logic [31:0] HEADER_BYTES   = 32'd54;

    localparam logic [1:0] COMP_BLUE  = 2'd0;
    localparam logic [1:0] COMP_GREEN = 2'd1;
    localparam logic [1:0] COMP_RED   = 2'd2;

endpackage
`default_nettype wire

/* hdl/bmp_stream_pixel_parser.sv */
// Streaming 24-bit bitmap parser: header fields, gap and row padding skip, one pixel per triple.
//
//   channel | valid   | ready   | payload
//   --------+---------+---------+---------------------------------------------------
//   in      | i_valid | o_ready | i_data_byte, i_file_start
//   out     | o_valid | i_ready | o_kind, o_red/green/blue, o_row, o_column,
//           |         |         | o_image_width/height, o_bit_depth, o_pixel_offset, o_last
//
// Each input word is handled in the cycle it is accepted, and its result (if any) appears
// in the output register on the next cycle, so one word per cycle is sustained while results are taken.
// The input is ready whenever the output register is empty or is being taken this cycle;
// a stalled result holds the input only until it leaves.
// The row padding multiply is spread over header bytes 30 and 31, never on the pixel path.
// Reset (synchronous, active low) waits for a start flag and empties the output register.
`default_nettype none
module bmp_stream_pixel_parser #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_file_start,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [11:0]      o_row,
    output logic [11:0]      o_column,
    output logic [12:0]      o_image_width,
    output logic [12:0]      o_image_height,
    output logic [15:0]      o_bit_depth,
    output logic [31:0]      o_pixel_offset,
    output logic             o_last
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int BW = 16 + WW;

    // Parser state.
    bsp_pkg::t_phase r_phase, n_phase;
    logic [31:0]     r_pos, n_pos;
    logic [31:0]     r_shift, n_shift;
    logic [WW-1:0]   r_width, n_width;
    logic            r_wover, n_wover;
    logic [HW-1:0]   r_height, n_height;
    logic            r_hover, n_hover;
    logic [15:0]     r_depth, n_depth;
    logic [31:0]     r_offset, n_offset;
    logic [BW-1:0]   r_bits, n_bits;
    logic [BW-1:0]   r_pad_len, n_pad_len;
    logic [BW-1:0]   r_pad_left, n_pad_left;
    logic [HW-1:0]   r_row, n_row;
    logic [WW-1:0]   r_col, n_col;
    logic [1:0]      r_comp, n_comp;
    logic [7:0]      r_blue, n_blue;
    logic [7:0]      r_green, n_green;

    // Output register.
    logic            r_ov, n_ov;
    bsp_pkg::t_kind  r_kind, n_kind;
    logic [7:0]      r_ored, n_ored;
    logic [7:0]      r_ogreen, n_ogreen;
    logic [7:0]      r_oblue, n_oblue;
    logic [HW-1:0]   r_orow, n_orow;
    logic [WW-1:0]   r_ocol, n_ocol;
    logic [WW-1:0]   r_owidth, n_owidth;
    logic [HW-1:0]   r_oheight, n_oheight;
    logic [15:0]     r_odepth, n_odepth;
    logic [31:0]     r_ooffset, n_ooffset;
    logic            r_olast, n_olast;

    logic            in_acc;
    logic [31:0]     shift_in;
    logic [31:0]     pos_inc;
    logic [BW-1:0]   product;
    logic [BW:0]     bits_sum;
    logic [BW-1:0]   row_size;
    logic [BW-1:0]   used_bytes;
    logic [WW-1:0]   col_inc;
    logic [HW-1:0]   row_inc;
    logic [WW+12:0]  ext_width;
    logic [HW+12:0]  ext_height;
    logic [HW+11:0]  ext_row;
    logic [WW+11:0]  ext_col;

    assign o_ready    = !r_ov || i_ready;
    assign in_acc     = i_valid && o_ready;
    assign shift_in   = {i_data_byte, r_shift[31:8]};
    assign pos_inc    = r_pos + 32'd1;
    assign product    = {{WW{1'b0}}, r_depth} * {16'b0, r_width};
    assign bits_sum   = {1'b0, r_bits} + (BW + 1)'(31);
    assign row_size   = {2'b00, bits_sum[BW:5], 2'b00};
    assign used_bytes = {16'b0, r_width} + {15'b0, r_width, 1'b0};
    assign col_inc    = r_col + WW'(1);
    assign row_inc    = r_row + HW'(1);

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_shift    = r_shift;
        n_width    = r_width;
        n_wover    = r_wover;
        n_height   = r_height;
        n_hover    = r_hover;
        n_depth    = r_depth;
        n_offset   = r_offset;
        n_bits     = r_bits;
        n_pad_len  = r_pad_len;
        n_pad_left = r_pad_left;
        n_row      = r_row;
        n_col      = r_col;
        n_comp     = r_comp;
        n_blue     = r_blue;
        n_green    = r_green;

        n_ov       = r_ov && !i_ready;
        n_kind     = r_kind;
        n_ored     = r_ored;
        n_ogreen   = r_ogreen;
        n_oblue    = r_oblue;
        n_orow     = r_orow;
        n_ocol     = r_ocol;
        n_owidth   = r_owidth;
        n_oheight  = r_oheight;
        n_odepth   = r_odepth;
        n_ooffset  = r_ooffset;
        n_olast    = r_olast;

        if (in_acc) begin
            // A start flag restarts parsing with this word as file byte zero.
            if (i_file_start) begin
                n_phase = bsp_pkg::PH_HEADER;
                n_pos   = '0;
                n_row   = '0;
                n_col   = '0;
                n_comp  = bsp_pkg::COMP_BLUE;
            end

            case (n_phase)
                bsp_pkg::PH_HEADER: begin
                    n_shift = shift_in;
                    n_pos   = n_pos + 32'd1;
                    if (n_pos == bsp_pkg::POS_OFFSET_END + 32'd1) begin
                        n_offset = shift_in;
                    end
                    if (n_pos == bsp_pkg::POS_WIDTH_END + 32'd1) begin
                        n_width = shift_in[WW-1:0];
                        n_wover = shift_in > 32'(MAX_WIDTH);
                    end
                    if (n_pos == bsp_pkg::POS_HEIGHT_END + 32'd1) begin
                        n_height = shift_in[HW-1:0];
                        n_hover  = shift_in > 32'(MAX_HEIGHT);
                    end
                    if (n_pos == bsp_pkg::POS_DEPTH_END + 32'd1) begin
                        n_depth = shift_in[31:16];
                    end
                    if (n_pos == bsp_pkg::POS_PRODUCT + 32'd1) begin
                        n_bits = product;
                    end
                    if (n_pos == bsp_pkg::POS_PADDING + 32'd1) begin
                        n_pad_len = (row_size > used_bytes) ? row_size - used_bytes : '0;
                    end
                    if (n_pos == bsp_pkg::POS_HEADER_END + 32'd1) begin
                        n_ov      = 1'b1;
                        n_ored    = '0;
                        n_ogreen  = '0;
                        n_oblue   = '0;
                        n_orow    = '0;
                        n_ocol    = '0;
                        if (r_wover || r_hover) begin
                            n_kind    = bsp_pkg::KIND_ERROR;
                            n_owidth  = '0;
                            n_oheight = '0;
                            n_odepth  = '0;
                            n_ooffset = '0;
                            n_olast   = 1'b1;
                            n_phase   = bsp_pkg::PH_IDLE;
                        end else begin
                            n_kind    = bsp_pkg::KIND_HEADER;
                            n_owidth  = r_width;
                            n_oheight = r_height;
                            n_odepth  = r_depth;
                            n_ooffset = r_offset;
                            n_olast   = (r_width == '0) || (r_height == '0);
                            if ((r_width == '0) || (r_height == '0)) begin
                                n_phase = bsp_pkg::PH_IDLE;
                            end else if (r_offset > bsp_pkg::HEADER_BYTES) begin
                                n_phase = bsp_pkg::PH_GAP;
                            end else begin
                                n_phase = bsp_pkg::PH_PIXELS;
                            end
                        end
                    end
                end
                bsp_pkg::PH_GAP: begin
                    n_pos = pos_inc;
                    if (pos_inc == r_offset) begin
                        n_phase = bsp_pkg::PH_PIXELS;
                    end
                end
                bsp_pkg::PH_PIXELS: begin
                    case (r_comp)
                        bsp_pkg::COMP_BLUE: begin
                            n_blue = i_data_byte;
                            n_comp = bsp_pkg::COMP_GREEN;
                        end
                        bsp_pkg::COMP_GREEN: begin
                            n_green = i_data_byte;
                            n_comp  = bsp_pkg::COMP_RED;
                        end
                        default: begin
                            n_ov      = 1'b1;
                            n_kind    = bsp_pkg::KIND_PIXEL;
                            n_ored    = i_data_byte;
                            n_ogreen  = r_green;
                            n_oblue   = r_blue;
                            n_orow    = r_row;
                            n_ocol    = r_col;
                            n_owidth  = '0;
                            n_oheight = '0;
                            n_odepth  = '0;
                            n_ooffset = '0;
                            n_olast   = (col_inc == r_width) && (row_inc == r_height);
                            n_comp    = bsp_pkg::COMP_BLUE;
                            if (col_inc == r_width) begin
                                if (row_inc == r_height) begin
                                    n_phase = bsp_pkg::PH_IDLE;
                                end else if (r_pad_len != '0) begin
                                    n_pad_left = r_pad_len;
                                    n_phase    = bsp_pkg::PH_PAD;
                                end else begin
                                    n_col = '0;
                                    n_row = row_inc;
                                end
                            end else begin
                                n_col = col_inc;
                            end
                        end
                    endcase
                end
                bsp_pkg::PH_PAD: begin
                    n_pad_left = r_pad_left - BW'(1);
                    if (r_pad_left == BW'(1)) begin
                        n_col   = '0;
                        n_row   = row_inc;
                        n_phase = bsp_pkg::PH_PIXELS;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bsp_pkg::PH_IDLE;
            r_pos   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_comp  <= bsp_pkg::COMP_BLUE;
            r_ov    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_row   <= n_row;
            r_col   <= n_col;
            r_comp  <= n_comp;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift    <= n_shift;
        r_width    <= n_width;
        r_wover    <= n_wover;
        r_height   <= n_height;
        r_hover    <= n_hover;
        r_depth    <= n_depth;
        r_offset   <= n_offset;
        r_bits     <= n_bits;
        r_pad_len  <= n_pad_len;
        r_pad_left <= n_pad_left;
        r_blue     <= n_blue;
        r_green    <= n_green;
        r_kind     <= n_kind;
        r_ored     <= n_ored;
        r_ogreen   <= n_ogreen;
        r_oblue    <= n_oblue;
        r_orow     <= n_orow;
        r_ocol     <= n_ocol;
        r_owidth   <= n_owidth;
        r_oheight  <= n_oheight;
        r_odepth   <= n_odepth;
        r_ooffset  <= n_ooffset;
        r_olast    <= n_olast;
    end

    // Dimensions wider or narrower than the port fields are masked or zero-extended.
    assign ext_width  = {13'b0, r_owidth};
    assign ext_height = {13'b0, r_oheight};
    assign ext_row    = {12'b0, r_orow};
    assign ext_col    = {12'b0, r_ocol};

    assign o_valid        = r_ov;
    assign o_kind         = r_kind;
    assign o_red          = r_ored;
    assign o_green        = r_ogreen;
    assign o_blue         = r_oblue;
    assign o_row          = ext_row[11:0];
    assign o_column       = ext_col[11:0];
    assign o_image_width  = ext_width[12:0];
    assign o_image_height = ext_height[12:0];
    assign o_bit_depth    = r_odepth;
    assign o_pixel_offset = r_ooffset;
    assign o_last         = r_olast;

`ifndef ASSERT_OFF
    a_pad_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == bsp_pkg::PH_PAD |-> r_pad_left != '0)
        else $error("padding phase entered with nothing left to skip");

    a_comp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_comp != 2'd3)
        else $error("component counter out of range");

    a_start_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_file_start |=> r_phase == bsp_pkg::PH_HEADER && r_pos == 32'd1)
        else $error("start word did not restart header parsing");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_kind == bsp_pkg::KIND_ERROR |-> r_olast && r_phase == bsp_pkg::PH_IDLE
            || $past(in_acc) == 1'b0 || r_phase == bsp_pkg::PH_HEADER)
        else $error("error result did not end the file");

    a_pixel_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == bsp_pkg::PH_PIXELS |-> r_col < r_width && r_row < r_height)
        else $error("pixel position beyond image dimensions");
`endif

endmodule
`default_nettype wire

/* test/bsp_result_checker.sv */
// Result checker for the bitmap parser: predicts every result from the accepted bytes and compares.
`default_nettype none
module bsp_result_checker #(
    parameter int MAX_W = 4096,
    parameter int MAX_H = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_file_start,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_red,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_blue,
    input  wire logic [11:0] i_row,
    input  wire logic [11:0] i_column,
    input  wire logic [12:0] i_image_width,
    input  wire logic [12:0] i_image_height,
    input  wire logic [15:0] i_bit_depth,
    input  wire logic [31:0] i_pixel_offset,
    input  wire logic        i_last,
    output int               o_errors,
    output int               o_pending
);

    typedef struct packed {
        bsp_pkg::t_kind kind;
        logic [7:0]     red;
        logic [7:0]     green;
        logic [7:0]     blue;
        logic [11:0]    row;
        logic [11:0]    column;
        logic [12:0]    width;
        logic [12:0]    height;
        logic [15:0]    depth;
        logic [31:0]    offset;
        logic           last;
    } t_parse_result;

    t_parse_result expected_q[$];
    t_parse_result seen;
    t_parse_result want;
    t_parse_result fresh;
    bit            fresh_valid;

    // Parser state, kept at the widths of the byte-level arithmetic.
    bsp_pkg::t_phase ph;
    logic [31:0]     pos;
    logic [31:0]     shift_reg;
    logic [31:0]     wid;
    logic [31:0]     hgt;
    logic [15:0]     dep;
    logic [31:0]     ofs;
    logic [31:0]     row_n;
    logic [31:0]     col_n;
    logic [1:0]      comp;
    logic [15:0]     blue_green;
    logic [31:0]     pad_len;
    logic [31:0]     pad_cnt;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    task clear_parser();
        ph         = bsp_pkg::PH_IDLE;
        pos        = '0;
        shift_reg  = '0;
        wid        = '0;
        hgt        = '0;
        dep        = '0;
        ofs        = '0;
        row_n      = '0;
        col_n      = '0;
        comp       = bsp_pkg::COMP_BLUE;
        blue_green = '0;
        pad_len    = '0;
        pad_cnt    = '0;
    endtask

    task parse_byte(input logic [7:0] b, input logic st, output bit got,
                    output t_parse_result r);
        logic [63:0] bits;
        logic [63:0] row_size;
        logic [63:0] used;
        logic        row_end;
        logic        fin_pix;
        begin
            got = 1'b0;
            r   = '0;
            if (st) begin
                clear_parser();
                ph = bsp_pkg::PH_HEADER;
            end
            case (ph)
                bsp_pkg::PH_HEADER: begin
                    shift_reg = {b, shift_reg[31:8]};
                    if (pos == bsp_pkg::POS_OFFSET_END) ofs = shift_reg;
                    else if (pos == bsp_pkg::POS_WIDTH_END) wid = shift_reg;
                    else if (pos == bsp_pkg::POS_HEIGHT_END) hgt = shift_reg;
                    else if (pos == bsp_pkg::POS_DEPTH_END) dep = shift_reg[31:16];
                    if (pos == bsp_pkg::POS_HEADER_END) begin
                        got = 1'b1;
                        if (wid > 32'(MAX_W) || hgt > 32'(MAX_H)) begin
                            r.kind = bsp_pkg::KIND_ERROR;
                            r.last = 1'b1;
                            ph     = bsp_pkg::PH_IDLE;
                        end else begin
                            bits     = 64'(dep) * 64'(wid);
                            row_size = ((bits + 64'd31) / 64'd32) * 64'd4;
                            used     = 64'd3 * 64'(wid);
                            pad_len  = (row_size > used) ? 32'(row_size - used) : 32'd0;
                            pad_cnt  = '0;
                            row_n    = '0;
                            col_n    = '0;
                            comp     = bsp_pkg::COMP_BLUE;
                            blue_green = '0;
                            r.kind   = bsp_pkg::KIND_HEADER;
                            r.width  = wid[12:0];
                            r.height = hgt[12:0];
                            r.depth  = dep;
                            r.offset = ofs;
                            if (wid == 0 || hgt == 0) begin
                                r.last = 1'b1;
                                ph     = bsp_pkg::PH_IDLE;
                            end else begin
                                ph = (ofs > bsp_pkg::HEADER_BYTES) ? bsp_pkg::PH_GAP
                                                                   : bsp_pkg::PH_PIXELS;
                            end
                        end
                    end
                    pos = pos + 32'd1;
                end
                bsp_pkg::PH_GAP: begin
                    pos = pos + 32'd1;
                    if (pos == ofs) ph = bsp_pkg::PH_PIXELS;
                end
                bsp_pkg::PH_PIXELS: begin
                    if (comp == bsp_pkg::COMP_BLUE) begin
                        blue_green = {8'h00, b};
                        comp       = bsp_pkg::COMP_GREEN;
                    end else if (comp == bsp_pkg::COMP_GREEN) begin
                        blue_green = {b, blue_green[7:0]};
                        comp       = bsp_pkg::COMP_RED;
                    end else begin
                        row_end  = (col_n + 32'd1 == wid);
                        fin_pix  = row_end && (row_n + 32'd1 == hgt);
                        got      = 1'b1;
                        r.kind   = bsp_pkg::KIND_PIXEL;
                        r.red    = b;
                        r.green  = blue_green[15:8];
                        r.blue   = blue_green[7:0];
                        r.row    = row_n[11:0];
                        r.column = col_n[11:0];
                        r.last   = fin_pix;
                        comp     = bsp_pkg::COMP_BLUE;
                        if (fin_pix) begin
                            ph = bsp_pkg::PH_IDLE;
                        end else if (row_end) begin
                            if (pad_len != 0) begin
                                pad_cnt = '0;
                                ph      = bsp_pkg::PH_PAD;
                            end else begin
                                col_n = '0;
                                row_n = row_n + 32'd1;
                            end
                        end else begin
                            col_n = col_n + 32'd1;
                        end
                    end
                end
                bsp_pkg::PH_PAD: begin
                    pad_cnt = pad_cnt + 32'd1;
                    if (pad_cnt >= pad_len) begin
                        pad_cnt = '0;
                        col_n   = '0;
                        row_n   = row_n + 32'd1;
                        ph      = bsp_pkg::PH_PIXELS;
                    end
                end
                default: ;
            endcase
        end
    endtask

    task note_error(input string what);
        o_errors++;
        if (o_errors <= 10) begin
            $display("%s: kind %0d/%0d rgb %h %h %h / %h %h %h row %0d/%0d col %0d/%0d",
                     what, want.kind, seen.kind, want.red, want.green, want.blue,
                     seen.red, seen.green, seen.blue, want.row, seen.row,
                     want.column, seen.column);
            $display("    width %0d/%0d height %0d/%0d depth %0d/%0d offset %h/%h last %0d/%0d",
                     want.width, seen.width, want.height, seen.height,
                     want.depth, seen.depth, want.offset, seen.offset, want.last, seen.last);
        end
    endtask

    // The result of a word accepted at one edge can leave at the next edge at the earliest,
    // so the output side is checked before the new word is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            expected_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                seen.kind   = bsp_pkg::t_kind'(i_kind);
                seen.red    = i_red;
                seen.green  = i_green;
                seen.blue   = i_blue;
                seen.row    = i_row;
                seen.column = i_column;
                seen.width  = i_image_width;
                seen.height = i_image_height;
                seen.depth  = i_bit_depth;
                seen.offset = i_pixel_offset;
                seen.last   = i_last;
                if (expected_q.size() == 0) begin
                    want = '0;
                    note_error("unexpected result (expected/actual)");
                end else begin
                    want = expected_q.pop_front();
                    if (seen !== want) note_error("result mismatch (expected/actual)");
                end
            end
            if (i_in_valid && i_in_ready) begin
                parse_byte(i_data_byte, i_file_start, fresh_valid, fresh);
                if (fresh_valid) expected_q.push_back(fresh);
            end
        end
        o_pending = expected_q.size();
    end

endmodule
`default_nettype wire

/* test/tb_top.sv */
// Testbench top for the bitmap parser: byte stream stimulus, random idling and the verdict.
`default_nettype none
module tb_top;

    localparam int MAX_W = 4096;
    localparam int MAX_H = 4096;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [7:0]  i_data_byte  = 8'h00;
    logic        i_file_start = 1'b0;
    logic        i_ready      = 1'b1;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [11:0] o_row;
    logic [11:0] o_column;
    logic [12:0] o_image_width;
    logic [12:0] o_image_height;
    logic [15:0] o_bit_depth;
    logic [31:0] o_pixel_offset;
    logic        o_last;

    int error_cnt;
    int pending_cnt;
    int bytes_sent = 0;
    int stall_left = 0;
    bit quiet      = 1'b0;

    always #1 i_clk = ~i_clk;

    bmp_stream_pixel_parser #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_file_start  (i_file_start),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_row         (o_row),
        .o_column      (o_column),
        .o_image_width (o_image_width),
        .o_image_height(o_image_height),
        .o_bit_depth   (o_bit_depth),
        .o_pixel_offset(o_pixel_offset),
        .o_last        (o_last)
    );

    bsp_result_checker #(
        .MAX_W(MAX_W),
        .MAX_H(MAX_H)
    ) u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_data_byte   (i_data_byte),
        .i_file_start  (i_file_start),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_kind        (o_kind),
        .i_red         (o_red),
        .i_green       (o_green),
        .i_blue        (o_blue),
        .i_row         (o_row),
        .i_column      (o_column),
        .i_image_width (o_image_width),
        .i_image_height(o_image_height),
        .i_bit_depth   (o_bit_depth),
        .i_pixel_offset(o_pixel_offset),
        .i_last        (o_last),
        .o_errors      (error_cnt),
        .o_pending     (pending_cnt)
    );

    // Receiver stalls come in bursts of random length.
    always @(negedge i_clk) begin
        if (quiet) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 16);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    function logic [7:0] pick_byte();
        if ($urandom_range(0, 3) == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        return 8'($urandom);
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task send_word(input logic st, input logic [7:0] data);
        int gap;
        begin
            if (!quiet && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 17);
                i_valid      <= 1'b0;
                i_data_byte  <= 8'($urandom);
                i_file_start <= 1'($urandom);
                repeat (gap) @(negedge i_clk);
            end
            i_valid      <= 1'b1;
            i_data_byte  <= data;
            i_file_start <= st;
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
            @(negedge i_clk);
            bytes_sent++;
        end
    endtask

    task send_noise(input int n, input bit allow_start);
        repeat (n) send_word(allow_start && $urandom_range(0, 15) == 0, pick_byte());
    endtask

    // Sends one file: header, gap up to the offset, rows with padding, then a few stray bytes.
    // Only the first budget bytes go out, which cuts the file short when the budget is small.
    task send_bitmap(input logic [31:0] ofs, input logic [31:0] wid, input logic [31:0] hgt,
                     input logic [15:0] dep, input int budget);
        logic [7:0] hdr [0:53];
        longint     gap_len;
        longint     row_sz;
        longint     used_len;
        longint     pad_len;
        longint     rows;
        int         sent;
        begin
            for (int k = 0; k < 54; k++) hdr[k] = 8'($urandom);
            if ($urandom_range(0, 3) != 0) begin
                hdr[0] = 8'h42;
                hdr[1] = 8'h4D;
            end
            for (int k = 0; k < 4; k++) begin
                hdr[10 + k] = ofs[8 * k +: 8];
                hdr[18 + k] = wid[8 * k +: 8];
                hdr[22 + k] = hgt[8 * k +: 8];
            end
            hdr[28] = dep[7:0];
            hdr[29] = dep[15:8];
            row_sz   = ((longint'(dep) * longint'(wid) + 31) / 32) * 4;
            used_len = 3 * longint'(wid);
            pad_len  = (row_sz > used_len) ? row_sz - used_len : 0;
            if (wid == 0 || hgt == 0 || wid > MAX_W || hgt > MAX_H) begin
                rows    = 0;
                gap_len = 0;
            end else begin
                rows    = longint'(hgt);
                gap_len = (ofs > 54) ? longint'(ofs) - 54 : 0;
            end
            sent = 0;
            for (int k = 0; k < 54 && sent < budget; k++) begin
                send_word(k == 0, hdr[k]);
                sent++;
            end
            for (longint g = 0; g < gap_len && sent < budget; g++) begin
                send_word(1'b0, pick_byte());
                sent++;
            end
            for (longint y = 0; y < rows && sent < budget; y++) begin
                for (longint x = 0; x < used_len && sent < budget; x++) begin
                    send_word(1'b0, pick_byte());
                    sent++;
                end
                for (longint q = 0; y + 1 < rows && q < pad_len && sent < budget; q++) begin
                    send_word(1'b0, pick_byte());
                    sent++;
                end
            end
            if (sent < budget) send_noise($urandom_range(0, 2), 1'b0);
        end
    endtask

    function logic [31:0] rand_dim(input int hi, input int cap);
        case ($urandom_range(0, 19))
            0:       return 32'd0;
            1:       return 32'(cap + $urandom_range(1, 3));
            2:       return 32'($urandom);
            default: return 32'($urandom_range(1, hi));
        endcase
    endfunction

    function logic [15:0] rand_depth();
        case ($urandom_range(0, 9))
            0:       return 16'd32;
            1:       return 16'd8;
            2:       return 16'd16;
            3:       return 16'd1;
            4:       return 16'd0;
            5:       return 16'($urandom_range(0, 64));
            default: return 16'd24;
        endcase
    endfunction

    function logic [31:0] rand_offset();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return 32'd54;
        if (pick < 7) return 32'($urandom_range(0, 53));
        return 32'($urandom_range(55, 70));
    endfunction

    initial begin
        int rand_start;
        int pick;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed files; some are cut short by their budget, in the header, the gap or the pixels.
        send_noise(3, 1'b0);
        send_bitmap(32'd54, 32'd2, 32'd2, 16'd24, 1 << 30);
        send_bitmap(32'd60, 32'd3, 32'd2, 16'd24, 1 << 30);
        send_bitmap(32'd0, 32'd1, 32'd1, 16'd24, 1 << 30);
        send_bitmap(32'd54, 32'd0, 32'd3, 16'd24, 1 << 30);
        send_bitmap(32'd54, 32'd2, 32'd0, 16'd24, 1 << 30);
        send_bitmap(32'd54, 32'(MAX_W + 1), 32'd1, 16'd24, 1 << 30);
        send_bitmap(32'd54, 32'd1, 32'(MAX_H + 1), 16'd24, 1 << 30);
        send_bitmap(32'd54, 32'd4, 32'd4, 16'd24, 70);
        send_bitmap(32'd54, 32'd4, 32'd4, 16'd24, 20);
        send_bitmap(32'hFFFF_FFFF, 32'd1, 32'd1, 16'd24, 62);
        send_bitmap(32'd54, 32'd2, 32'd2, 16'd0, 1 << 30);
        send_bitmap(32'd57, 32'd2, 32'd2, 16'd32, 1 << 30);
        send_bitmap(32'd54, 32'(MAX_W), 32'd1, 16'd24, 60);
        send_bitmap(32'd54, 32'd1, 32'(MAX_H), 16'd24, 60);

        // Random files, mostly well formed, some cut short, some pure noise.
        rand_start = bytes_sent;
        while (bytes_sent - rand_start < 100) begin
            if (bytes_sent - rand_start >= 60) quiet = 1'b1;
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                send_noise($urandom_range(1, 40), 1'b1);
            end else begin
                send_bitmap(rand_offset(), rand_dim(6, MAX_W), rand_dim(4, MAX_H),
                            rand_depth(), (pick < 5) ? $urandom_range(1, 80) : (1 << 30));
            end
        end
        quiet = 1'b1;
        i_valid <= 1'b0;

        while (pending_cnt != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (error_cnt == 0 && pending_cnt == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
